@@ hw/rtl/lphm_pkg.sv @@
// ----------------------------------------------------------------------------
// lphm_pkg: shared types and constants for the linear probing hash map
// Commands, result status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package lphm_pkg;

  // Default sizes. SLOTS must be a power of two.
  localparam int DEF_SLOTS      = 1024;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_VALUE_BITS = 32;

  // Fixed widths of the result fields.
  localparam int STATUS_BITS = 2;
  localparam int FOUND_BITS  = 32;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_CHECK
  } state_t;

endpackage

@@ hw/rtl/lphm_hash.sv @@
// ----------------------------------------------------------------------------
// lphm_hash: slot index hash
// Folds the key into slot index width by XORing its index-wide chunks.
// ----------------------------------------------------------------------------
module lphm_hash #(
  parameter int KEY_BITS = lphm_pkg::DEF_KEY_BITS,
  parameter int IDX_BITS = 10
) (
  input  logic [KEY_BITS-1:0] key,
  output logic [IDX_BITS-1:0] idx
);

  localparam int NCHUNK   = (KEY_BITS + IDX_BITS - 1) / IDX_BITS;
  localparam int EXT_BITS = NCHUNK * IDX_BITS;

  logic [EXT_BITS-1:0] key_ext;

  assign key_ext = EXT_BITS'(key);

  // The chunks are independent, so this is a flat XOR tree.
  always_comb begin
    logic [IDX_BITS-1:0] h;
    h = '0;
    for (int i = 0; i < NCHUNK; i++) begin
      h = h ^ key_ext[i*IDX_BITS +: IDX_BITS];
    end
    idx = h;
  end

endmodule

@@ hw/rtl/lphm_ram.sv @@
// ----------------------------------------------------------------------------
// lphm_ram: slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lphm_ram #(
  parameter int DEPTH = lphm_pkg::DEF_SLOTS,
  parameter int WIDTH = 1 + lphm_pkg::DEF_KEY_BITS + lphm_pkg::DEF_VALUE_BITS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/linear_probe_hash_map.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_map: open addressing hash table with linear probing
// Inserts key and value pairs and looks keys up in a slot memory, one slot
// visited per cycle by a small sequencer.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  -----------------------------
// command   in         start high, busy low      command, key, value
// result    out        done high for one cycle   status, found_value
//
// After reset the block sweeps the slot memory once, clearing every valid
// mark, one slot per cycle with busy high. A new item is accepted only once
// the previous one is finished; the single slot memory read port visits one
// slot per cycle while probing. A refused insert leaves the block idle.
// The result strobe is registered and the receiver cannot stall it, so each
// result is signalled by done high for a single cycle.
// ----------------------------------------------------------------------------
module linear_probe_hash_map #(
  parameter int SLOTS      = lphm_pkg::DEF_SLOTS,
  parameter int KEY_BITS   = lphm_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lphm_pkg::DEF_VALUE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [0:0]                        command,
  input  logic [KEY_BITS-1:0]               key,
  input  logic [VALUE_BITS-1:0]             value,
  output logic                              done,
  output logic [lphm_pkg::STATUS_BITS-1:0]  status,
  output logic [lphm_pkg::FOUND_BITS-1:0]   found_value
);

  localparam int IDX_BITS  = $clog2(SLOTS);
  localparam int HALF      = SLOTS / 2;
  localparam int CNT_BITS  = $clog2(HALF + 1);
  localparam int WORD_BITS = 1 + KEY_BITS + VALUE_BITS;

  // Sequencer and item registers.
  lphm_pkg::state_t state, state_next;
  logic [IDX_BITS-1:0]   clr_addr;
  logic [IDX_BITS-1:0]   idx;
  logic [IDX_BITS-1:0]   probe_cnt;
  lphm_pkg::cmd_t        cmd_reg;
  logic [KEY_BITS-1:0]   key_reg;
  logic [VALUE_BITS-1:0] value_reg;
  logic [CNT_BITS-1:0]   entry_count;

  // Result registers.
  lphm_pkg::status_t             status_reg;
  logic [lphm_pkg::FOUND_BITS-1:0] found_reg;

  // Memory port signals.
  logic                 ram_we;
  logic [IDX_BITS-1:0]  ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [IDX_BITS-1:0]  ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // Decoded slot word and probe decisions.
  logic                  rd_valid;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_value;
  logic                  hit;
  logic                  last_probe;
  logic                  finish;
  logic [IDX_BITS-1:0]   idx_inc;
  logic [IDX_BITS-1:0]   hash_idx;
  lphm_pkg::cmd_t        cmd_in;
  logic                  accept;
  logic                  refuse;
  logic                  ins_write;

  // Result produced this cycle, registered onto the result ports.
  logic                            res_fire;
  lphm_pkg::status_t               res_status;
  logic [lphm_pkg::FOUND_BITS-1:0] res_found;

  lphm_hash #(
    .KEY_BITS (KEY_BITS),
    .IDX_BITS (IDX_BITS)
  ) u_hash (
    .key (key),
    .idx (hash_idx)
  );

  lphm_ram #(
    .DEPTH (SLOTS),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy   = (state != lphm_pkg::S_IDLE);
  assign accept = start && !busy;
  assign cmd_in = lphm_pkg::cmd_t'(command);

  // An insert is refused up front once half the slots are taken, which also
  // guarantees an insert always finds an empty slot.
  assign refuse = (cmd_in == lphm_pkg::CMD_INSERT) &&
                  (entry_count >= CNT_BITS'(HALF));

  // The slot word is {valid, key, value}.
  assign rd_valid = ram_rdata[WORD_BITS-1];
  assign rd_key   = ram_rdata[KEY_BITS+VALUE_BITS-1 -: KEY_BITS];
  assign rd_value = ram_rdata[VALUE_BITS-1:0];

  assign idx_inc    = idx + IDX_BITS'(1);
  assign hit        = rd_valid && (rd_key == key_reg);
  assign last_probe = (probe_cnt == {IDX_BITS{1'b1}});

  // A probe run ends at an empty slot, at a matching key for a lookup, or
  // after every slot has been visited once.
  assign finish = !rd_valid || ((cmd_reg == lphm_pkg::CMD_LOOKUP) && hit) || last_probe;

  assign ins_write = (state == lphm_pkg::S_CHECK) && !rd_valid &&
                     (cmd_reg == lphm_pkg::CMD_INSERT);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      lphm_pkg::S_CLEAR: begin
        if (clr_addr == {IDX_BITS{1'b1}}) begin
          state_next = lphm_pkg::S_IDLE;
        end
      end
      lphm_pkg::S_IDLE: begin
        if (accept && !refuse) begin
          state_next = lphm_pkg::S_PROBE;
        end
      end
      lphm_pkg::S_PROBE: begin
        state_next = lphm_pkg::S_CHECK;
      end
      lphm_pkg::S_CHECK: begin
        if (finish) begin
          state_next = lphm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lphm_pkg::S_IDLE;
      end
    endcase
  end

  // Memory control and result decode.
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = idx;
    ram_wdata  = {1'b1, key_reg, value_reg};
    ram_raddr  = idx;
    res_fire   = 1'b0;
    res_status = lphm_pkg::STAT_MISS;
    res_found  = '0;
    case (state)
      lphm_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      lphm_pkg::S_IDLE: begin
        res_fire   = accept && refuse;
        res_status = lphm_pkg::STAT_FULL;
      end
      lphm_pkg::S_PROBE: begin
        ram_raddr = idx;
      end
      lphm_pkg::S_CHECK: begin
        // Read the following slot ahead so a probe run moves one slot a cycle.
        ram_raddr = idx_inc;
        ram_we    = ins_write;
        res_fire  = finish;
        if (!rd_valid) begin
          res_status = (cmd_reg == lphm_pkg::CMD_INSERT) ? lphm_pkg::STAT_OK
                                                         : lphm_pkg::STAT_MISS;
        end else if ((cmd_reg == lphm_pkg::CMD_LOOKUP) && hit) begin
          res_status = lphm_pkg::STAT_OK;
          res_found  = lphm_pkg::FOUND_BITS'(rd_value);
        end else begin
          // Every slot visited without an ending condition.
          res_status = (cmd_reg == lphm_pkg::CMD_INSERT) ? lphm_pkg::STAT_FULL
                                                         : lphm_pkg::STAT_MISS;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lphm_pkg::S_CLEAR;
      clr_addr    <= '0;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_fire;
      if (state == lphm_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + IDX_BITS'(1);
      end
      if (ins_write) begin
        entry_count <= entry_count + CNT_BITS'(1);
      end
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_reg   <= cmd_in;
      key_reg   <= key;
      value_reg <= value;
      idx       <= hash_idx;
      probe_cnt <= '0;
    end else if ((state == lphm_pkg::S_CHECK) && !finish) begin
      idx       <= idx_inc;
      probe_cnt <= probe_cnt + IDX_BITS'(1);
    end
    if (res_fire) begin
      status_reg <= res_status;
      found_reg  <= res_found;
    end
  end

  assign status      = status_reg;
  assign found_value = found_reg;

  // A refused insert answers full on the very next cycle.
  a_refuse_full: assert property (@(posedge clk) disable iff (rst)
    (accept && refuse) |=> (done && (status == lphm_pkg::STAT_FULL)))
    else $error("refused insert did not answer full");

  // The fill count never passes the half-full limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_BITS'(HALF))
    else $error("entry count above half the slots");

  // The slot memory is written only by the clearing sweep or an insert.
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == lphm_pkg::S_CLEAR) || (state == lphm_pkg::S_CHECK)))
    else $error("slot write outside clearing or probing");

  // A result is shown only once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == lphm_pkg::S_IDLE))
    else $error("result strobe while busy");

  // Every insert write adds one to the fill count.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ins_write |=> (entry_count == $past(entry_count) + CNT_BITS'(1)))
    else $error("fill count not advanced by insert");

endmodule
